// ===== rtl/wsht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wsht_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DISPOSE = 3'd1,
    OP_SHOW    = 3'd2,
    OP_HIDE    = 3'd3,
    OP_SELECT  = 3'd4,
    OP_ORIGIN  = 3'd5,
    OP_FIND    = 3'd6
  } op_t;

  localparam logic [2:0] REGION_DESK    = 3'd0;
  localparam logic [2:0] REGION_MENU    = 3'd1;
  localparam logic [2:0] REGION_CONTENT = 3'd2;
  localparam logic [2:0] REGION_DRAG    = 3'd3;
  localparam logic [2:0] REGION_CLOSE   = 3'd4;

  localparam int BOX_INSET = 6;
  localparam int BOX_SIZE  = 12;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_BUBBLE,
    MODE_APPEND,
    MODE_REMOVE
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic active;
    logic found;
  } carry_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/wsht_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wsht_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [3:0]        window_slot;
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] right;
  logic signed [15:0] bottom;
  logic [3:0]        proc_kind;
  logic              make_visible;
  logic              wants_close_box;
  logic signed [15:0] point_h;
  logic signed [15:0] point_v;

  modport source(output valid, operation, window_slot, left, top, right, bottom, proc_kind,
                 make_visible, wants_close_box, point_h, point_v, input ready);
  modport sink(input valid, operation, window_slot, left, top, right, bottom, proc_kind,
               make_visible, wants_close_box, point_h, point_v, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsht_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wsht_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] region;
  logic       hit_valid;
  logic [3:0] hit_slot;
  logic       alloc_ok;
  logic [3:0] new_slot;
  logic       front_valid;
  logic [3:0] front_slot;

  modport source(output valid, region, hit_valid, hit_slot, alloc_ok, new_slot, front_valid,
                 front_slot, input ready);
  modport sink(input valid, region, hit_valid, hit_slot, alloc_ok, new_slot, front_valid,
               front_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsht_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsht_cell
  import wsht_pkg::*;
#(
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cell_mode_t    mode,
  input  wire logic          tok_in,
  input  wire carry_ctl_t    ctl_in,
  input  wire logic [SW-1:0] cslot_in,
  input  wire logic [SW-1:0] tgt_slot,
  input  wire logic          up_valid,
  input  wire logic [SW-1:0] up_slot,
  output logic               tok,
  output carry_ctl_t         ctl,
  output logic [SW-1:0]      cslot,
  output logic               valid,
  output logic [SW-1:0]      slot,
  output logic               here
);

  logic          valid_next;
  logic [SW-1:0] slot_next;
  carry_ctl_t    ctl_next;
  logic [SW-1:0] cslot_next;
  logic          match;

  assign match = valid && (slot == tgt_slot);
  assign here  = tok_in && valid;

  always_comb begin
    valid_next = valid;
    slot_next  = slot;
    ctl_next   = ctl_in;
    cslot_next = cslot_in;
    case (mode)
      MODE_BUBBLE: begin
        // swap the carried slot in; stop at the old copy or the end
        if (ctl_in.active) begin
          valid_next = 1'b1;
          slot_next  = cslot_in;
          if (!valid || match) begin
            ctl_next.active = 1'b0;
          end else begin
            cslot_next = slot;
          end
        end
      end
      MODE_APPEND: begin
        if (ctl_in.active && !valid) begin
          valid_next      = 1'b1;
          slot_next       = cslot_in;
          ctl_next.active = 1'b0;
        end
      end
      MODE_REMOVE: begin
        // pull the upper neighbor down from the match onward
        if (ctl_in.found || match) begin
          valid_next     = up_valid;
          slot_next      = up_slot;
          ctl_next.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= 1'b0;
      valid <= 1'b0;
      ctl   <= '0;
    end else begin
      tok <= tok_in;
      ctl <= ctl_next;
      if (tok_in) begin
        valid <= valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    cslot <= cslot_next;
    if (tok_in) begin
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/window_stack_hit_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Modport  Contents
// req      in   sink     operation, slot, bounds, kind, flags, point
// rsp      out  source   region, hit, allocated slot, front of stack
//
// A token walks the row of stack cells one cell per cycle, and the hit test follows
// it through a registered read stage.
// The result sits in an output register; a new item is taken while it waits.
// Reset (rst, synchronous) empties the stack and frees every slot.
// A stalled rsp holds the finished result; the walk of the next item still runs.
module window_stack_hit_test
  import wsht_pkg::*;
#(
  parameter int MAX_WINDOWS      = 16,
  parameter int TITLE_BAR_HEIGHT = 20,
  parameter int MENU_BAR_HEIGHT  = 20
) (
  input wire logic  clk,
  input wire logic  rst,
  wsht_req_if.sink  req,
  wsht_rsp_if.source rsp
);

  localparam int SW = $clog2(MAX_WINDOWS);
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam logic signed [16:0] MENU_H  = 17'(MENU_BAR_HEIGHT);
  localparam logic [15:0]        TITLE_H = 16'(TITLE_BAR_HEIGHT);
  localparam logic [15:0]        BOX_OFF = 16'((TITLE_BAR_HEIGHT - BOX_SIZE) / 2);

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic accept, start, load, busy_done;

  // slot pool
  logic [MAX_WINDOWS-1:0] in_use, visible, has_title, has_close;
  logic [15:0] origin_h [MAX_WINDOWS];
  logic [15:0] origin_v [MAX_WINDOWS];
  logic [15:0] win_width [MAX_WINDOWS];
  logic [15:0] win_height [MAX_WINDOWS];

  // item registers
  cell_mode_t    mode;
  logic [SW-1:0] carry_slot;
  logic          is_find, is_menu, alloc_ok, done_alloc;
  logic [SW-1:0] alloc_slot;
  logic signed [15:0] pt_h, pt_v;

  // cell row
  logic          tok_c   [MAX_WINDOWS+1];
  carry_ctl_t    ctl_c   [MAX_WINDOWS+1];
  logic [SW-1:0] cslot_c [MAX_WINDOWS+1];
  logic [MAX_WINDOWS-1:0] valid_c, here_c;
  logic [SW-1:0] slot_c [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] tok_vec;

  // find stage
  logic          sel_valid;
  logic [SW-1:0] sel_slot;
  logic          rd_valid, rd_title, rd_close, rd_vis;
  logic [SW-1:0] rd_slot;
  logic signed [15:0] rd_oh, rd_ov, rd_w, rd_h;
  logic          f_found;
  logic [2:0]    f_region;
  logic [SW-1:0] f_slot;

  // request decode
  logic [SW+3:0] tgt_wide;
  logic [SW-1:0] tgt;
  logic          live;
  logic [SW-1:0] free_slot;
  logic          free_ok;
  logic          title_req;
  logic signed [16:0] dw, dh;

  logic out_full;

  assign tgt_wide  = {{SW{1'b0}}, req.window_slot};
  assign tgt       = tgt_wide[SW-1:0];
  assign live      = (tgt_wide < (SW+4)'(MAX_WINDOWS)) && in_use[tgt];
  assign title_req = req.proc_kind inside {4'd0, 4'd4};
  assign dw        = 17'(req.right) - 17'(req.left);
  assign dh        = 17'(req.bottom) - 17'(req.top);

  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot = SW'(i);
        free_ok   = 1'b1;
      end
    end
  end

  // FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_SWEEP;
      ST_SWEEP:  if (busy_done) state_next = ST_FINISH;
      ST_FINISH: if (!out_full || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    start     = (state == ST_SWEEP) && (cnt == '0);
    busy_done = (state == ST_SWEEP) && (cnt == CW'(MAX_WINDOWS));
    load      = (state == ST_FINISH) && (!out_full || rsp.ready);
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // pool flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      visible   <= '0;
      has_title <= '0;
      has_close <= '0;
    end else if (accept) begin
      case (op_t'(req.operation))
        OP_CREATE: if (free_ok) begin
          in_use[free_slot]    <= 1'b1;
          visible[free_slot]   <= req.make_visible;
          has_title[free_slot] <= title_req;
          has_close[free_slot] <= title_req && req.wants_close_box;
        end
        OP_DISPOSE: if (live) in_use[tgt] <= 1'b0;
        OP_SHOW:    if (live) visible[tgt] <= 1'b1;
        OP_HIDE:    if (live) visible[tgt] <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // geometry store
  always_ff @(posedge clk) begin
    if (accept && (op_t'(req.operation) == OP_CREATE) && free_ok) begin
      origin_h[free_slot]   <= req.left;
      origin_v[free_slot]   <= req.top;
      win_width[free_slot]  <= (dw < 17'sd1) ? 16'd1 : dw[15:0];
      win_height[free_slot] <= (dh < 17'sd1) ? 16'd1 : dh[15:0];
    end else if (accept && (op_t'(req.operation) == OP_ORIGIN) && live) begin
      origin_h[tgt] <= req.left;
      origin_v[tgt] <= req.top;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NONE;
      is_find <= 1'b0;
    end else if (accept) begin
      mode    <= MODE_NONE;
      is_find <= (op_t'(req.operation) == OP_FIND);
      case (op_t'(req.operation))
        OP_CREATE:            if (free_ok) mode <= req.make_visible ? MODE_BUBBLE : MODE_APPEND;
        OP_DISPOSE:           if (live) mode <= MODE_REMOVE;
        OP_SHOW, OP_SELECT:   if (live) mode <= MODE_BUBBLE;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      carry_slot <= (op_t'(req.operation) == OP_CREATE) ? free_slot : tgt;
      alloc_ok   <= (op_t'(req.operation) == OP_CREATE) && free_ok;
      alloc_slot <= free_slot;
      is_menu    <= 17'(req.point_v) < MENU_H;
      pt_h       <= req.point_h;
      pt_v       <= req.point_v;
    end
  end

  // cell row
  assign tok_c[0]   = start;
  assign ctl_c[0]   = '{active: 1'b1, found: 1'b0};
  assign cslot_c[0] = carry_slot;

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    logic          up_v;
    logic [SW-1:0] up_s;
    if (i < MAX_WINDOWS - 1) begin : g_up
      assign up_v = valid_c[i+1];
      assign up_s = slot_c[i+1];
    end else begin : g_top
      assign up_v = 1'b0;
      assign up_s = '0;
    end
    wsht_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .mode     (mode),
      .tok_in   (tok_c[i]),
      .ctl_in   (ctl_c[i]),
      .cslot_in (cslot_c[i]),
      .tgt_slot (carry_slot),
      .up_valid (up_v),
      .up_slot  (up_s),
      .tok      (tok_c[i+1]),
      .ctl      (ctl_c[i+1]),
      .cslot    (cslot_c[i+1]),
      .valid    (valid_c[i]),
      .slot     (slot_c[i]),
      .here     (here_c[i])
    );
    assign tok_vec[i] = tok_c[i];
  end

  always_comb begin
    sel_valid = |here_c;
    sel_slot  = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      sel_slot = sel_slot | (here_c[i] ? slot_c[i] : '0);
    end
  end

  // read stage of the hit test
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SWEEP) && sel_valid && is_find && !is_menu;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot  <= sel_slot;
    rd_vis   <= visible[sel_slot];
    rd_title <= has_title[sel_slot];
    rd_close <= has_close[sel_slot];
    rd_oh    <= origin_h[sel_slot];
    rd_ov    <= origin_v[sel_slot];
    rd_w     <= win_width[sel_slot];
    rd_h     <= win_height[sel_slot];
  end

  logic signed [15:0] fr, ft, fb, bl, bt;
  logic signed [17:0] bl_end, bt_end;
  logic in_frame, in_box;
  logic [2:0] hit_region;

  always_comb begin
    ft     = rd_ov - (rd_title ? TITLE_H : 16'd0);
    fr     = rd_oh + rd_w;
    fb     = rd_ov + rd_h;
    bl     = rd_oh + 16'(BOX_INSET);
    bt     = ft + BOX_OFF;
    bl_end = 18'(bl) + 18'sd12;
    bt_end = 18'(bt) + 18'sd12;
    in_frame = (pt_h >= rd_oh) && (pt_h < fr) && (pt_v >= ft) && (pt_v < fb);
    in_box = (pt_h >= bl) && (18'(pt_h) < bl_end) && (pt_v >= bt) && (18'(pt_v) < bt_end);
    hit_region = REGION_CONTENT;
    if (rd_title && (pt_v < rd_ov)) begin
      hit_region = (rd_close && in_box) ? REGION_CLOSE : REGION_DRAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_found <= 1'b0;
    end else if (accept) begin
      f_found <= 1'b0;
    end else if (rd_valid && rd_vis && in_frame && !f_found) begin
      f_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_vis && in_frame && !f_found) begin
      f_region <= hit_region;
      f_slot   <= rd_slot;
    end
  end

  // output register
  logic [SW+3:0] hs_w, ns_w, fs_w;
  assign hs_w = {4'd0, f_slot};
  assign ns_w = {4'd0, alloc_slot};
  assign fs_w = {4'd0, slot_c[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (load) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.region      <= !is_find ? REGION_DESK : is_menu ? REGION_MENU :
                         f_found ? f_region : REGION_DESK;
      rsp.hit_valid   <= is_find && !is_menu && f_found;
      rsp.hit_slot    <= (is_find && !is_menu && f_found) ? hs_w[3:0] : 4'd0;
      rsp.alloc_ok    <= alloc_ok;
      rsp.new_slot    <= alloc_ok ? ns_w[3:0] : 4'd0;
      rsp.front_valid <= valid_c[0];
      rsp.front_slot  <= valid_c[0] ? fs_w[3:0] : 4'd0;
    end
  end

  assign rsp.valid = out_full;

`ifndef SYNTH
  a_accept_walks : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SWEEP)
    else $error("accepted item did not start a walk");
  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one token in the cell row");
  a_stack_packed : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (valid_c & (valid_c + MAX_WINDOWS'(1))) == '0)
    else $error("stack cells hold a gap");
  a_alloc_marks : assert property (@(posedge clk) disable iff (rst)
    accept && (op_t'(req.operation) == OP_CREATE) && free_ok |=> in_use[$past(free_slot)])
    else $error("created slot not marked in use");
`endif

endmodule
`default_nettype wire

// ===== bench/window_stack_hit_test_test.sv =====
`timescale 1ns / 1ps
module window_stack_hit_test_test;
  import wsht_pkg::*;

  localparam int SLOTS = 16;
  localparam int TITLE_H = 20;
  localparam int MENU_H = 20;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic signed [15:0] l, t, r, b;
    logic [3:0]         kind;
    logic               vis, cls;
    logic signed [15:0] ph, pv;
  } win_cmd_t;

  typedef struct {
    logic [2:0] region;
    logic       hit_valid;
    logic [3:0] hit_slot;
    logic       alloc_ok;
    logic [3:0] new_slot;
    logic       front_valid;
    logic [3:0] front_slot;
  } win_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  wsht_req_if req();
  wsht_rsp_if rsp();

  window_stack_hit_test uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window pool mirror
  bit in_use[SLOTS], shown[SLOTS], titled[SLOTS], boxed[SLOTS];
  int org_h[SLOTS], org_v[SLOTS], wid[SLOTS], hgt[SLOTS];
  int z_order[SLOTS];
  int z_count;

  win_cmd_t    cmd_queue[$];
  win_status_t status_queue[$];
  int  accepted = 0;
  int  errors = 0;
  bit  req_took = 0;

  function automatic int wrap16(int x);
    return int'($signed(x[15:0]));
  endfunction

  function automatic void unlink(int s);
    for (int i = 0; i < z_count; i++) begin
      if (z_order[i] == s) begin
        for (int j = i; j + 1 < z_count; j++) z_order[j] = z_order[j + 1];
        z_count--;
        return;
      end
    end
  endfunction

  function automatic void raise_front(int s);
    unlink(s);
    if (z_count < SLOTS) begin
      for (int i = z_count; i > 0; i--) z_order[i] = z_order[i - 1];
      z_order[0] = s;
      z_count++;
    end
  endfunction

  function automatic win_status_t apply_cmd(win_cmd_t c);
    win_status_t st;
    int s, i, w, tb, fl, ft, fr, fb, bl, bt, ph, pv;
    bit title, live;
    st = '{default: '0};
    s = int'(c.slot);
    live = in_use[s];
    ph = int'(c.ph);
    pv = int'(c.pv);
    if (c.op == OP_CREATE) begin
      for (i = 0; i < SLOTS; i++) if (!in_use[i]) break;
      if (i < SLOTS) begin
        title = (c.kind == 0 || c.kind == 4);
        in_use[i] = 1;
        titled[i] = title;
        boxed[i] = title && c.cls;
        shown[i] = c.vis;
        wid[i] = (int'(c.r) - int'(c.l) < 1) ? 1 : int'(c.r) - int'(c.l);
        hgt[i] = (int'(c.b) - int'(c.t) < 1) ? 1 : int'(c.b) - int'(c.t);
        org_h[i] = int'(c.l);
        org_v[i] = int'(c.t);
        if (c.vis) raise_front(i);
        else if (z_count < SLOTS) begin
          z_order[z_count] = i;
          z_count++;
        end
        st.alloc_ok = 1;
        st.new_slot = 4'(i);
      end
    end else if (c.op >= OP_DISPOSE && c.op <= OP_ORIGIN && live) begin
      case (c.op)
        OP_DISPOSE: begin
          unlink(s);
          in_use[s] = 0;
        end
        OP_SHOW: begin
          shown[s] = 1;
          raise_front(s);
        end
        OP_HIDE: shown[s] = 0;
        OP_SELECT: raise_front(s);
        default: begin
          org_h[s] = int'(c.l);
          org_v[s] = int'(c.t);
        end
      endcase
    end else if (c.op == OP_FIND) begin
      if (pv < MENU_H) st.region = REGION_MENU;
      else begin
        for (i = 0; i < z_count; i++) begin
          w = z_order[i];
          if (!shown[w]) continue;
          tb = titled[w] ? TITLE_H : 0;
          fl = wrap16(org_h[w]);
          ft = wrap16(org_v[w] - tb);
          fb = wrap16(org_v[w] + hgt[w]);
          fr = wrap16(org_h[w] + wid[w]);
          if (ph < fl || ph >= fr || pv < ft || pv >= fb) continue;
          st.hit_valid = 1;
          st.hit_slot = 4'(w);
          st.region = REGION_CONTENT;
          if (titled[w] && pv < org_v[w]) begin
            st.region = REGION_DRAG;
            if (boxed[w]) begin
              bl = wrap16(fl + BOX_INSET);
              bt = wrap16(ft + (TITLE_H - BOX_SIZE) / 2);
              if (ph >= bl && ph < bl + BOX_SIZE && pv >= bt && pv < bt + BOX_SIZE)
                st.region = REGION_CLOSE;
            end
          end
          break;
        end
      end
    end
    st.front_valid = z_count > 0;
    st.front_slot = z_count > 0 ? 4'(z_order[0]) : 4'd0;
    return st;
  endfunction

  function automatic win_cmd_t noise_cmd();
    win_cmd_t c;
    c.op = 3'($urandom);
    c.slot = 4'($urandom);
    c.l = 16'($urandom);
    c.t = 16'($urandom);
    c.r = 16'($urandom);
    c.b = 16'($urandom);
    c.kind = 4'($urandom);
    c.vis = 1'($urandom);
    c.cls = 1'($urandom);
    c.ph = 16'($urandom);
    c.pv = 16'($urandom);
    return c;
  endfunction

  function automatic void push(win_cmd_t c);
    cmd_queue.push_back(c);
    status_queue.push_back(apply_cmd(c));
  endfunction

  function automatic win_cmd_t make_create(int l, int t, int r, int b, int kind, bit vis,
                                           bit cls);
    win_cmd_t c;
    c = noise_cmd();
    c.op = OP_CREATE;
    c.l = 16'(l);
    c.t = 16'(t);
    c.r = 16'(r);
    c.b = 16'(b);
    c.kind = 4'(kind);
    c.vis = vis;
    c.cls = cls;
    return c;
  endfunction

  function automatic win_cmd_t make_find(int ph, int pv);
    win_cmd_t c;
    c = noise_cmd();
    c.op = OP_FIND;
    c.ph = 16'(ph);
    c.pv = 16'(pv);
    return c;
  endfunction

  function automatic win_cmd_t make_slot_op(logic [2:0] op, int s);
    win_cmd_t c;
    c = noise_cmd();
    c.op = op;
    c.slot = 4'(s);
    return c;
  endfunction

  function automatic int pick_used_slot();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) if (in_use[(s + k) % SLOTS]) return (s + k) % SLOTS;
    return s;
  endfunction

  function automatic win_cmd_t random_cmd();
    win_cmd_t c;
    int pick, s, l, t;
    pick = $urandom_range(0, 99);
    s = pick_used_slot();
    if (pick < 25) begin
      l = $urandom_range(0, 600) - 100;
      t = $urandom_range(0, 400) - 20;
      c = make_create(l, t, l + $urandom_range(0, 180) - 10, t + $urandom_range(0, 150) - 10,
                      ($urandom_range(0, 1) ? ($urandom_range(0, 1) ? 4 : 0)
                                            : $urandom_range(0, 15)),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 1);
    end else if (pick < 60) begin
      if ($urandom_range(0, 3) == 0)
        c = make_find(org_h[s] + BOX_INSET + $urandom_range(0, 13) - 1,
                      org_v[s] - TITLE_H + 4 + $urandom_range(0, 13) - 1);
      else
        c = make_find(org_h[s] + $urandom_range(0, wid[s] > 300 ? 300 : wid[s] + 2) - 1,
                      org_v[s] - TITLE_H + $urandom_range(0, hgt[s] > 300 ? 320 : hgt[s] + 22)
                      - 1);
    end else if (pick < 90) begin
      c = make_slot_op(3'($urandom_range(OP_DISPOSE, OP_ORIGIN)),
                       $urandom_range(0, 9) == 0 ? $urandom_range(0, SLOTS - 1) : s);
      if (c.op == OP_DISPOSE && $urandom_range(0, 1)) c = make_slot_op(OP_SELECT, s);
      if (c.op == OP_ORIGIN && $urandom_range(0, 4) != 0) begin
        c.l = 16'($urandom_range(0, 600) - 100);
        c.t = 16'($urandom_range(0, 400) - 20);
      end
    end else begin
      c = noise_cmd();
    end
    return c;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    win_status_t e;
    req_took = req.valid && req.ready;
    if (!rst && rsp.valid && rsp.ready) begin
      if (status_queue.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual region %0d front %0d",
                 $realtime, rsp.region, rsp.front_slot);
        errors++;
      end else begin
        e = status_queue.pop_front();
        check_field("region", e.region, rsp.region);
        check_field("hit_valid", e.hit_valid, rsp.hit_valid);
        check_field("hit_slot", e.hit_slot, rsp.hit_slot);
        check_field("alloc_ok", e.alloc_ok, rsp.alloc_ok);
        check_field("new_slot", e.new_slot, rsp.new_slot);
        check_field("front_valid", e.front_valid, rsp.front_valid);
        check_field("front_slot", e.front_slot, rsp.front_slot);
      end
    end
  end

  function automatic int send_idle_pct();
    return accepted < 350 ? 19 : (accepted < 700 ? 83 : 0);
  endfunction

  function automatic int recv_idle_pct();
    return accepted < 350 ? 83 : (accepted < 700 ? 19 : 0);
  endfunction

  // hold the payload until the transfer, then advance
  always @(negedge clk) begin
    win_cmd_t c;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req_took) begin
        void'(cmd_queue.pop_front());
        accepted++;
      end
      if (!(req.valid && !req_took)) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          c = cmd_queue[0];
          req.valid <= 1'b1;
          req.operation <= c.op;
          req.window_slot <= c.slot;
          req.left <= c.l;
          req.top <= c.t;
          req.right <= c.r;
          req.bottom <= c.b;
          req.proc_kind <= c.kind;
          req.make_visible <= c.vis;
          req.wants_close_box <= c.cls;
          req.point_h <= c.ph;
          req.point_v <= c.pv;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    rsp.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct());
  end

  initial begin
    req.valid = 1'b0;
    req.operation = OP_FIND;
    req.window_slot = '0;
    req.left = '0;
    req.top = '0;
    req.right = '0;
    req.bottom = '0;
    req.proc_kind = '0;
    req.make_visible = 1'b0;
    req.wants_close_box = 1'b0;
    req.point_h = '0;
    req.point_v = '0;
    rsp.ready = 1'b0;
    z_count = 0;

    push(make_find(-32768, -32768));
    push(make_find(100, 100));
    push(make_create(0, 40, 200, 140, 0, 1'b1, 1'b1));
    push(make_create(50, 60, 250, 160, 4, 1'b0, 1'b1));
    push(make_create(100, 60, 300, 200, 1, 1'b1, 1'b1));
    push(make_create(32767, 32767, -32768, -32768, 0, 1'b1, 1'b0));
    push(make_create(-32768, -32768, 32767, 32767, 4, 1'b1, 1'b1));
    push(make_slot_op(OP_HIDE, 4));
    push(make_find(6, 24));
    push(make_find(100, 30));
    push(make_find(150, 100));
    push(make_find(150, 19));
    push(make_find(60, 150));
    push(make_slot_op(OP_SHOW, 1));
    push(make_find(60, 150));
    push(make_slot_op(OP_HIDE, 2));
    push(make_slot_op(OP_SELECT, 0));
    push(make_find(150, 100));
    begin
      win_cmd_t c;
      c = make_slot_op(OP_ORIGIN, 0);
      c.l = -16'sd32768;
      c.t = 16'sd32767;
      push(c);
      c = make_slot_op(OP_UNUSED, 0);
      push(c);
    end
    push(make_slot_op(OP_DISPOSE, 3));
    push(make_slot_op(OP_DISPOSE, 3));
    push(make_slot_op(OP_SHOW, 15));
    for (int k = 0; k < 13; k++) push(make_create(10 * k, 30 + 10 * k, 10 * k + 80,
                                                   90 + 10 * k, k % 5, k % 2 == 1, 1'b1));
    for (int k = 0; k < 1050; k++) push(random_cmd());

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (cmd_queue.size() == 0 && status_queue.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && status_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
